/* hdl/tlpq_pkg.sv */
package tlpq_pkg;

	localparam int DATA_W   = 32;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;
	localparam int PADDR_W  = 3;

	// Register map
	localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
	localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = 32'sd64;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH      = 2'd0,
		FUNC_PRIO_PUSH = 2'd1,
		FUNC_POP       = 2'd2,
		FUNC_NOP       = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Which queue offset the datapath reads
	typedef enum logic [1:0] {
		RD_HEAD   = 2'd0,
		RD_IDX    = 2'd1,
		RD_IDX_M1 = 2'd2
	} rd_mode_t;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_POP      = 8'b0000_0010,
		ST_SCAN_RD  = 8'b0000_0100,
		ST_SCAN_CHK = 8'b0000_1000,
		ST_SHIFT_RD = 8'b0001_0000,
		ST_SHIFT_WR = 8'b0010_0000,
		ST_INSERT   = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic     accept;
		logic     push_tail;
		logic     pop_take;
		logic     scan_start;
		logic     scan_next;
		logic     set_pos;
		logic     shift_step;
		logic     insert;
		logic     res_load;
		rd_mode_t rd_mode;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic in_prio;
		logic ent_prio;
		logic idx_at_count;
		logic idx_at_pos;
		logic out_free;
	} sts_t;

endpackage

/* hdl/tlpq_if.sv */
interface tlpq_req_if;
	logic                                valid;
	logic                                ready;
	logic [tlpq_pkg::FUNC_W-1:0]         func;
	logic signed [tlpq_pkg::DATA_W-1:0]  in_value;

	modport source (output valid, func, in_value, input ready);
	modport sink   (input valid, func, in_value, output ready);
endinterface

interface tlpq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [tlpq_pkg::DATA_W-1:0]  out_value;
	logic                                out_valid;
	logic [tlpq_pkg::STATUS_W-1:0]       status;
	logic [tlpq_pkg::OCC_W-1:0]          occupancy;

	modport source (output valid, out_value, out_valid, status, occupancy, input ready);
	modport sink   (input valid, out_value, out_valid, status, occupancy, output ready);
endinterface

/* hdl/tlpq_ctrl.sv */
module tlpq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [tlpq_pkg::FUNC_W-1:0] in_func,
	output logic                        in_ready,
	input  tlpq_pkg::sts_t              sts,
	output tlpq_pkg::cmd_t              cmd
);

	tlpq_pkg::state_t state_q;
	tlpq_pkg::state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlpq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Take a new transaction only between operations
	assign in_ready = (state_q == tlpq_pkg::ST_IDLE);

	// Next state and datapath commands
	always_comb begin
		cmd         = '0;
		cmd.rd_mode = tlpq_pkg::RD_HEAD;
		state_nxt   = state_q;
		case (state_q)
			tlpq_pkg::ST_IDLE: begin
				cmd.rd_mode = tlpq_pkg::RD_HEAD;
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (tlpq_pkg::func_t'(in_func))
						tlpq_pkg::FUNC_PUSH: begin
							cmd.push_tail = !sts.full;
							state_nxt     = tlpq_pkg::ST_DONE;
						end
						tlpq_pkg::FUNC_PRIO_PUSH: begin
							if (sts.full) begin
								state_nxt = tlpq_pkg::ST_DONE;
							end else if (sts.in_prio) begin
								cmd.scan_start = 1'b1;
								state_nxt      = tlpq_pkg::ST_SCAN_RD;
							end else begin
								cmd.push_tail = 1'b1;
								state_nxt     = tlpq_pkg::ST_DONE;
							end
						end
						tlpq_pkg::FUNC_POP: begin
							state_nxt = sts.empty ? tlpq_pkg::ST_DONE : tlpq_pkg::ST_POP;
						end
						tlpq_pkg::FUNC_NOP: begin
							state_nxt = tlpq_pkg::ST_DONE;
						end
						default: begin
							state_nxt = tlpq_pkg::ST_DONE;
						end
					endcase
				end
			end
			// Head entry is in the read register now
			tlpq_pkg::ST_POP: begin
				cmd.pop_take = 1'b1;
				state_nxt    = tlpq_pkg::ST_DONE;
			end
			// Walk the priority run from the head
			tlpq_pkg::ST_SCAN_RD: begin
				cmd.rd_mode = tlpq_pkg::RD_IDX;
				if (sts.idx_at_count) begin
					cmd.set_pos = 1'b1;
					state_nxt   = tlpq_pkg::ST_SHIFT_RD;
				end else begin
					state_nxt = tlpq_pkg::ST_SCAN_CHK;
				end
			end
			tlpq_pkg::ST_SCAN_CHK: begin
				if (sts.ent_prio) begin
					cmd.scan_next = 1'b1;
					state_nxt     = tlpq_pkg::ST_SCAN_RD;
				end else begin
					cmd.set_pos = 1'b1;
					state_nxt   = tlpq_pkg::ST_SHIFT_RD;
				end
			end
			// Move entries one place toward the tail, from the tail down
			tlpq_pkg::ST_SHIFT_RD: begin
				if (sts.idx_at_pos) begin
					state_nxt = tlpq_pkg::ST_INSERT;
				end else begin
					cmd.rd_mode = tlpq_pkg::RD_IDX_M1;
					state_nxt   = tlpq_pkg::ST_SHIFT_WR;
				end
			end
			tlpq_pkg::ST_SHIFT_WR: begin
				cmd.shift_step = 1'b1;
				state_nxt      = tlpq_pkg::ST_SHIFT_RD;
			end
			tlpq_pkg::ST_INSERT: begin
				cmd.insert = 1'b1;
				state_nxt  = tlpq_pkg::ST_DONE;
			end
			// Hold the result until the output register is free
			tlpq_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_nxt    = tlpq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = tlpq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* hdl/tlpq_dp.sv */
module tlpq_dp #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tlpq_pkg::cmd_t                      cmd,
	output tlpq_pkg::sts_t                      sts,
	input  logic [tlpq_pkg::FUNC_W-1:0]         in_func,
	input  logic signed [tlpq_pkg::DATA_W-1:0]  in_value,
	input  logic signed [tlpq_pkg::DATA_W-1:0]  threshold,
	input  logic                                rsp_ready,
	output logic                                rsp_valid,
	output logic signed [tlpq_pkg::DATA_W-1:0]  out_value,
	output logic                                out_valid,
	output logic [tlpq_pkg::STATUS_W-1:0]       status,
	output logic [tlpq_pkg::OCC_W-1:0]          occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	// Circular store, head at head_q
	logic [tlpq_pkg::DATA_W-1:0] mem [DEPTH];
	logic [tlpq_pkg::DATA_W-1:0] rd_data_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic [tlpq_pkg::DATA_W-1:0] val_q;

	logic [tlpq_pkg::DATA_W-1:0] res_value_q;
	logic                        res_ov_q;
	tlpq_pkg::status_t           res_status_q;
	tlpq_pkg::status_t           acc_status;

	logic                        out_full_q;
	logic [tlpq_pkg::DATA_W-1:0] out_value_q;
	logic                        out_ov_q;
	tlpq_pkg::status_t           out_status_q;
	logic [tlpq_pkg::OCC_W-1:0]  out_occ_q;

	logic [CW-1:0]               rd_off;
	logic [CW-1:0]               wr_off;
	logic [AW-1:0]               rd_addr;
	logic [AW-1:0]               wr_addr;
	logic                        wr_en;
	logic [tlpq_pkg::DATA_W-1:0] wr_data;

	// Map a queue offset to a store address, wrapping once
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
	                                       input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(head) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	// Read and write address selection
	always_comb begin
		case (cmd.rd_mode)
			tlpq_pkg::RD_HEAD:   rd_off = '0;
			tlpq_pkg::RD_IDX:    rd_off = idx_q;
			tlpq_pkg::RD_IDX_M1: rd_off = idx_q - CW'(1);
			default:             rd_off = '0;
		endcase
	end

	assign wr_en   = cmd.push_tail | cmd.shift_step | cmd.insert;
	assign wr_off  = cmd.push_tail ? count_q : (cmd.shift_step ? idx_q : pos_q);
	assign wr_data = cmd.push_tail ? in_value : (cmd.shift_step ? rd_data_q : val_q);
	assign rd_addr = phys(head_q, rd_off);
	assign wr_addr = phys(head_q, wr_off);

	// Store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Head, count and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
		end else begin
			if (cmd.pop_take) begin
				head_q  <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
				count_q <= count_q - CW'(1);
			end else if (cmd.push_tail || cmd.insert) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.scan_next) begin
				idx_q <= idx_q + CW'(1);
			end else if (cmd.set_pos) begin
				idx_q <= count_q;
				pos_q <= idx_q;
			end else if (cmd.shift_step) begin
				idx_q <= idx_q - CW'(1);
			end
		end
	end

	// Status of the accepted transaction
	always_comb begin
		acc_status = tlpq_pkg::STATUS_OK;
		if (in_func inside {tlpq_pkg::FUNC_PUSH, tlpq_pkg::FUNC_PRIO_PUSH}) begin
			if (sts.full) begin
				acc_status = tlpq_pkg::STATUS_FULL;
			end
		end else if (in_func == tlpq_pkg::FUNC_POP) begin
			if (sts.empty) begin
				acc_status = tlpq_pkg::STATUS_EMPTY;
			end
		end
	end

	// Pending result
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q        <= in_value;
			res_value_q  <= '0;
			res_ov_q     <= 1'b0;
			res_status_q <= acc_status;
		end else if (cmd.pop_take) begin
			res_value_q <= rd_data_q;
			res_ov_q    <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_full_q <= 1'b1;
		end else if (rsp_ready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_value_q  <= res_value_q;
			out_ov_q     <= res_ov_q;
			out_status_q <= res_status_q;
			out_occ_q    <= tlpq_pkg::OCC_W'(count_q);
		end
	end

	assign rsp_valid = out_full_q;
	assign out_value = $signed(out_value_q);
	assign out_valid = out_ov_q;
	assign status    = out_status_q;
	assign occupancy = out_occ_q;

	// Status to the controller
	assign sts.full         = (count_q == CW'(DEPTH));
	assign sts.empty        = (count_q == '0);
	assign sts.in_prio      = (in_value > threshold);
	assign sts.ent_prio     = ($signed(rd_data_q) > threshold);
	assign sts.idx_at_count = (idx_q == count_q);
	assign sts.idx_at_pos   = (idx_q == pos_q);
	assign sts.out_free     = !out_full_q || rsp_ready;

endmodule

/* hdl/two_level_priority_queue_unit.sv */
// Channel  Dir  Handshake         Payload
// req      in   valid/ready       func, in_value
// rsp      out  valid/ready       out_value, out_valid, status, occupancy
// apb      in   psel/penable      paddr, pwdata, pwrite -> prdata, pready
//
// One transaction at a time. Plain push, rejected ops and no-op go from idle
// straight to done; pop passes through the pop state. A priority push above the
// threshold walks the store through its single read port, scanning the priority
// run, then shifting entries one place toward the tail; at or below the threshold it is a plain push.
// Reset clears count, head, controller and the output full flag; entries need no clear.
// A stalled rsp holds the next result in the done state; req.ready stays low meanwhile.
module two_level_priority_queue_unit #(
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	tlpq_req_if.sink                             req,
	tlpq_rsp_if.source                           rsp,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [tlpq_pkg::PADDR_W-1:0]         paddr,
	input  logic [tlpq_pkg::DATA_W-1:0]          pwdata,
	output logic [tlpq_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);

	logic signed [tlpq_pkg::DATA_W-1:0] threshold_q;
	tlpq_pkg::cmd_t                     cmd;
	tlpq_pkg::sts_t                     sts;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= tlpq_pkg::THRESHOLD_RESET;
		end else if (psel && penable && pwrite && paddr == tlpq_pkg::ADDR_THRESHOLD) begin
			threshold_q <= $signed(pwdata);
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == tlpq_pkg::ADDR_THRESHOLD) ? threshold_q : '0;

	tlpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_func  (req.func),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tlpq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_func   (req.func),
		.in_value  (req.in_value),
		.threshold (threshold_q),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.out_value (rsp.out_value),
		.out_valid (rsp.out_valid),
		.status    (rsp.status),
		.occupancy (rsp.occupancy)
	);

	// Only one transaction in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("new transaction taken while one is in progress");

	// A popped value always comes with ok status
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.out_valid) |-> (rsp.status == tlpq_pkg::STATUS_OK))
		else $error("popped value with error status");

	// Empty pop reports an empty queue
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == tlpq_pkg::STATUS_EMPTY) |-> (rsp.occupancy == '0))
		else $error("empty status with nonzero occupancy");

	// Dropped push reports a full queue
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == tlpq_pkg::STATUS_FULL)
		|-> (rsp.occupancy == tlpq_pkg::OCC_W'(DEPTH)))
		else $error("full status with occupancy below depth");

endmodule
